### hw/rtl/pva_pkg.sv
package pva_pkg;

    // Number of voices held by the allocator.
    localparam int NUM_VOICES = 15;
    localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(NUM_VOICES - 1);

    // Request command codes.
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] request_priority;
        logic [3:0] voice_index;
    } pva_req_t;

    typedef struct packed {
        logic       granted;
        logic [3:0] granted_voice;
        logic       was_stolen;
    } pva_rsp_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_req;
        logic decide;
        logic scan_step;
        logic emit;
    } pva_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_release;
        logic idle_any;
        logic scan_hit;
        logic scan_last;
    } pva_status_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECIDE = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_DONE   = 4'b1000
    } pva_state_t;

endpackage

### hw/rtl/pva_ctrl.sv
module pva_ctrl
    import pva_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    input  pva_status_t status,
    output pva_cmd_t    cmd
);

    pva_state_t state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (status.is_release || status.idle_any)
                    state_next = ST_DONE;
                else
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_hit || status.scan_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // The result waits here until the output register is free.
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.emit)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

### hw/rtl/pva_datapath.sv
module pva_datapath
    import pva_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pva_req_t    req,
    input  pva_cmd_t    cmd,
    output pva_status_t status,
    output pva_rsp_t    rsp
);

    logic [NUM_VOICES-1:0] busy_reg, busy_next;
    logic [7:0]            prio_reg [NUM_VOICES];
    logic [7:0]            prio_next [NUM_VOICES];
    logic [VIDX_W-1:0]     steal_ptr_reg, steal_ptr_next;

    pva_req_t              req_reg, req_next;
    logic [VIDX_W-1:0]     scan_idx_reg, scan_idx_next;
    logic [VIDX_W-1:0]     scan_cnt_reg, scan_cnt_next;
    pva_rsp_t              res_reg, res_next;
    pva_rsp_t              rsp_reg, rsp_next;

    logic [VIDX_W-1:0]     first_idle;
    logic [VIDX_W-1:0]     rel_idx;
    logic [VIDX_W-1:0]     scan_idx_inc;
    logic                  rel_in_range;

    // Lowest-numbered idle voice.
    always_comb
    begin
        first_idle = '0;
        for (int i = NUM_VOICES - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
                first_idle = VIDX_W'(i);
        end
    end

    assign rel_in_range = (32'(req_reg.voice_index) < 32'(NUM_VOICES));
    assign rel_idx      = VIDX_W'(req_reg.voice_index);
    assign scan_idx_inc = (scan_idx_reg == LAST_VOICE) ? '0 : scan_idx_reg + 1'b1;

    assign status.is_release = (req_reg.cmd == CMD_RELEASE);
    assign status.idle_any   = !(&busy_reg);
    assign status.scan_hit   = (prio_reg[scan_idx_reg] <= req_reg.request_priority);
    assign status.scan_last  = (scan_cnt_reg == LAST_VOICE);

    assign rsp = rsp_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        prio_next      = prio_reg;
        steal_ptr_next = steal_ptr_reg;
        req_next       = req_reg;
        scan_idx_next  = scan_idx_reg;
        scan_cnt_next  = scan_cnt_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;

        if (cmd.load_req)
            req_next = req;

        if (cmd.decide)
        begin
            res_next = '0;
            if (status.is_release)
            begin
                if (rel_in_range)
                    busy_next[rel_idx] = 1'b0;
            end
            else if (status.idle_any)
            begin
                busy_next[first_idle]  = 1'b1;
                prio_next[first_idle]  = req_reg.request_priority;
                res_next.granted       = 1'b1;
                res_next.granted_voice = 4'(first_idle);
            end
            else
            begin
                scan_idx_next = steal_ptr_reg;
                scan_cnt_next = '0;
            end
        end

        if (cmd.scan_step)
        begin
            if (status.scan_hit)
            begin
                prio_next[scan_idx_reg] = req_reg.request_priority;
                steal_ptr_next          = scan_idx_inc;
                res_next.granted        = 1'b1;
                res_next.granted_voice  = 4'(scan_idx_reg);
                res_next.was_stolen     = 1'b1;
            end
            else
            begin
                scan_idx_next = scan_idx_inc;
                scan_cnt_next = scan_cnt_reg + 1'b1;
            end
        end

        if (cmd.emit)
            rsp_next = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            steal_ptr_reg <= '0;
            for (int i = 0; i < NUM_VOICES; i++)
                prio_reg[i] <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            steal_ptr_reg <= steal_ptr_next;
            prio_reg      <= prio_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        scan_idx_reg <= scan_idx_next;
        scan_cnt_reg <= scan_cnt_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

endmodule

### hw/rtl/priority_voice_allocator_top.sv
// Channel   Direction  Handshake                Payload
// request   in         req_valid / req_ready    req (pva_req_t: cmd, priority, voice)
// response  out        rsp_valid / rsp_ready    rsp (pva_rsp_t: granted, voice, stolen)
//
// A release or a grant of an idle voice goes from the decide state straight to the done
// state, and the next request is taken once the response has been emitted.
// A steal walks the stored priorities one voice per cycle from the steal pointer,
// visiting at most NUM_VOICES voices.
// Reset makes every voice idle, clears the stored priorities and the steal pointer.
// A stalled response sits in the output register while the next request is worked on.
module priority_voice_allocator_top
    import pva_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  pva_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output pva_rsp_t rsp
);

    // The controller sequences each request through decide and done states, with scan
    // states between them for a steal; the datapath holds the voice table and the result registers.
    pva_cmd_t    cmd;
    pva_status_t status;

    pva_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pva_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule
